/* rtl/core/kif_pkg.sv */
`default_nettype none

package kif_pkg;

    localparam int KIF_MAX_WIDTH   = 1024;
    localparam int KIF_KERNEL_SIZE = 3;
    localparam int KIF_COEF_BITS   = 16;
    localparam int MAX_HEIGHT      = 1024;
    localparam int LEVEL_MAX       = 255;

    localparam int SLOT_BITS = 16;
    localparam int PIX_W     = 24;
    localparam int ACC_W     = 30;
    localparam int WT_W      = 20;
    localparam int HW        = 11;
    localparam int CFG_W     = 11;
    localparam int ADDR_W    = 6;
    localparam int DIV_STEPS = 8;

    localparam logic [2:0] REG_MASK_TOP    = 3'd0;
    localparam logic [2:0] REG_MASK_MIDDLE = 3'd1;
    localparam logic [2:0] REG_MASK_BOTTOM = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd3;
    localparam logic [2:0] REG_IMAGE_HGT   = 3'd4;
    localparam logic [2:0] REG_GRAY_MODE   = 3'd5;

    typedef struct packed {
        logic clear;
        logic mac;
        logic div_start;
    } t_lane_ctl;

    function automatic logic [1:0] cell_row(input logic [3:0] idx);
        logic [1:0] r;
        case (idx)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cell_col(input logic [3:0] idx);
        logic [1:0] c;
        case (idx)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            4'd2, 4'd5, 4'd8: c = 2'd2;
            default:          c = 2'd1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/kif_history.sv */
`default_nettype none

module kif_history import kif_pkg::*; #(
    parameter int DEPTH = 2 * KIF_MAX_WIDTH + 4,
    parameter int AW    = $clog2(2 * KIF_MAX_WIDTH + 4)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [PIX_W-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/kif_lane.sv */
`default_nettype none

module kif_lane import kif_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_lane_ctl                   i_ctl,
    input  wire logic signed [SLOT_BITS-1:0] i_coef,
    input  wire logic        [7:0]           i_pix,
    input  wire logic signed [WT_W-1:0]      i_weight,
    output logic             [7:0]           o_level
);

    logic signed [ACC_W-1:0]     r_acc;
    logic        [ACC_W-1:0]     r_rem;
    logic        [ACC_W-1:0]     r_div;
    logic        [7:0]           r_q;
    logic                        r_sat;
    logic        [3:0]           r_steps;
    logic signed [SLOT_BITS+8:0] w_prod;
    logic signed [ACC_W-1:0]     w_wt_ext;

    assign w_prod   = i_coef * $signed({1'b0, i_pix});
    assign w_wt_ext = ACC_W'(i_weight);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.mac) begin
            r_acc <= r_acc + ACC_W'(w_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else if (i_ctl.div_start) begin
            if (r_acc <= 0) begin
                r_sat   <= 1'b0;
                r_q     <= '0;
                r_steps <= '0;
            end else if (i_weight > 0) begin
                r_q <= '0;
                if (r_acc >= (w_wt_ext <<< 8)) begin
                    r_sat   <= 1'b1;
                    r_steps <= '0;
                end else begin
                    r_sat   <= 1'b0;
                    r_rem   <= ACC_W'(r_acc);
                    r_div   <= ACC_W'(w_wt_ext <<< 7);
                    r_steps <= 4'(DIV_STEPS);
                end
            end else begin
                r_sat   <= |r_acc[ACC_W-2:16];
                r_q     <= r_acc[15:8];
                r_steps <= '0;
            end
        end else if (r_steps != '0) begin
            if (r_rem >= r_div) begin
                r_rem <= r_rem - r_div;
                r_q   <= {r_q[6:0], 1'b1};
            end else begin
                r_q <= {r_q[6:0], 1'b0};
            end
            r_div   <= r_div >> 1;
            r_steps <= r_steps - 4'd1;
        end
    end

    assign o_level = r_sat ? 8'(LEVEL_MAX) : r_q;

endmodule

`default_nettype wire

/* rtl/core/kernel_3x3_image_filter.sv */
`default_nettype none

// channel   direction  handshake                      payload
// config    in         psel/penable/pwrite, pready    paddr, pwdata, prdata
// pixel     in         i_valid / o_ready              i_op, i_red, i_green, i_blue
// filtered  out        o_valid / i_ready              o_out_red/green/blue, o_frame_last
//
// a request that yields no result is done on accept; one that yields a result is
// accepted, reads the window through the registered line memory port, passes the lane
// dividers (load, 8 quotient steps, 1 more), then loads the output register
// synchronous active-low reset; the line memory is never cleared
// o_ready is low from a result-making accept until its result is loaded; a full
// output register that is not taken holds the load and so the input

module kernel_3x3_image_filter import kif_pkg::*; #(
    parameter int MAX_WIDTH   = KIF_MAX_WIDTH,
    parameter int KERNEL_SIZE = KIF_KERNEL_SIZE,
    parameter int COEF_BITS   = KIF_COEF_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    output logic                   pready,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_op,
    input  wire logic [7:0]        i_red,
    input  wire logic [7:0]        i_green,
    input  wire logic [7:0]        i_blue,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [7:0]        o_out_red,
    output logic      [7:0]        o_out_green,
    output logic      [7:0]        o_out_blue,
    output logic                   o_frame_last
);

    localparam int HIST   = 2 * MAX_WIDTH + 4;
    localparam int AW     = $clog2(HIST);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int NCELL  = KERNEL_SIZE * KERNEL_SIZE;
    localparam int CELL_W = $clog2(NCELL + 1);
    localparam int OFF_W  = AW + 2;
    localparam int SH     = SLOT_BITS - COEF_BITS;
    localparam int RST_W  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_GATHER = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [47:0]      r_mask [3];
    logic [CFG_W-1:0] r_img_w;
    logic [CFG_W-1:0] r_img_h;
    logic             r_gray;
    logic             w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask[0] <= '0;
            r_mask[1] <= 48'd16777216;
            r_mask[2] <= '0;
            r_img_w   <= CFG_W'(1024);
            r_img_h   <= CFG_W'(1024);
            r_gray    <= 1'b0;
        end else if (w_cfg_we) begin
            case (paddr[ADDR_W-1:3])
                REG_MASK_TOP:    r_mask[0] <= pwdata[47:0];
                REG_MASK_MIDDLE: r_mask[1] <= pwdata[47:0];
                REG_MASK_BOTTOM: r_mask[2] <= pwdata[47:0];
                REG_IMAGE_WIDTH: r_img_w   <= pwdata[CFG_W-1:0];
                REG_IMAGE_HGT:   r_img_h   <= pwdata[CFG_W-1:0];
                REG_GRAY_MODE:   r_gray    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:3])
            REG_MASK_TOP:    prdata = {16'd0, r_mask[0]};
            REG_MASK_MIDDLE: prdata = {16'd0, r_mask[1]};
            REG_MASK_BOTTOM: prdata = {16'd0, r_mask[2]};
            REG_IMAGE_WIDTH: prdata = 64'(r_img_w);
            REG_IMAGE_HGT:   prdata = 64'(r_img_h);
            REG_GRAY_MODE:   prdata = 64'(r_gray);
            default:         prdata = '0;
        endcase
    end

    logic signed [SLOT_BITS-1:0] w_coef [NCELL];
    logic signed [WT_W-1:0]      w_wsum;
    logic signed [WT_W-1:0]      r_weight;

    for (genvar g = 0; g < NCELL; g++) begin : g_coef
        logic [SLOT_BITS-1:0] w_slot_sh;
        assign w_slot_sh =
            r_mask[g / KERNEL_SIZE][SLOT_BITS*(g % KERNEL_SIZE) +: SLOT_BITS] << SH;
        assign w_coef[g] = $signed(w_slot_sh) >>> SH;
    end

    always_comb begin
        w_wsum = '0;
        for (int i = 0; i < NCELL; i++) begin
            w_wsum = w_wsum + WT_W'(w_coef[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_weight <= w_wsum;
    end

    logic [WW-1:0] w_sat_w;
    logic [HW-1:0] w_sat_h;

    always_comb begin
        if (r_img_w == '0) begin
            w_sat_w = WW'(1);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            w_sat_w = WW'(MAX_WIDTH);
        end else begin
            w_sat_w = WW'(r_img_w);
        end
        if (r_img_h == '0) begin
            w_sat_h = HW'(1);
        end else if (32'(r_img_h) > MAX_HEIGHT) begin
            w_sat_h = HW'(MAX_HEIGHT);
        end else begin
            w_sat_h = HW'(r_img_h);
        end
    end

    logic [1:0]        r_state;
    logic [CELL_W-1:0] r_cell;
    logic [CELL_W-1:0] r_mac_cell;
    logic              r_mac_vld;
    logic [WW-1:0]     r_fw;
    logic [HW-1:0]     r_fh;
    logic [WW-1:0]     r_col;
    logic [HW-1:0]     r_row;
    logic [AW-1:0]     r_wptr;
    logic [CW-1:0]     r_wcnt;
    logic [WW-1:0]     r_ex;
    logic [HW-1:0]     r_ey;
    logic [AW-1:0]     r_eptr;
    logic              r_out_valid;
    logic [7:0]        r_out_red;
    logic [7:0]        r_out_green;
    logic [7:0]        r_out_blue;
    logic              r_out_last;

    logic          w_accept;
    logic          w_complete;
    logic          w_first;
    logic [WW-1:0] w_fw_eff;
    logic          w_hist_we;
    logic [CW-1:0] n_wcnt;
    logic          w_emit_start;
    logic          w_load;
    logic          w_last;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid & o_ready;
    assign w_complete = (r_row >= r_fh);
    assign w_first    = (r_row == '0) && (r_col == '0);
    assign w_fw_eff   = w_first ? w_sat_w : r_fw;
    assign w_hist_we  = w_accept && !w_complete && !i_op;
    assign n_wcnt     = r_wcnt + CW'(1);
    assign w_emit_start = w_accept &&
        (w_complete || (!i_op && (n_wcnt >= CW'(w_fw_eff) + CW'(2))));
    assign w_load     = (r_state == S_OUT) && (!r_out_valid || i_ready);
    assign w_last     = (r_ex == r_fw - WW'(1)) && (r_ey == r_fh - HW'(1));

    logic [1:0]              w_crow;
    logic [1:0]              w_ccol;
    logic signed [OFF_W-1:0] w_off;
    logic signed [OFF_W-1:0] w_asum;
    logic [AW-1:0]           w_raddr;

    always_comb begin
        w_crow = cell_row(4'(r_cell));
        w_ccol = cell_col(4'(r_cell));
        w_off  = '0;
        if (w_crow == 2'd0 && r_ey != '0) begin
            w_off = w_off - $signed(OFF_W'(r_fw));
        end else if (w_crow == 2'd2 && r_ey != r_fh - HW'(1)) begin
            w_off = w_off + $signed(OFF_W'(r_fw));
        end
        if (w_ccol == 2'd0 && r_ex != '0) begin
            w_off = w_off - OFF_W'(1);
        end else if (w_ccol == 2'd2 && r_ex != r_fw - WW'(1)) begin
            w_off = w_off + OFF_W'(1);
        end
        w_asum = $signed(OFF_W'(r_eptr)) + w_off;
        if (w_asum < 0) begin
            w_asum = w_asum + OFF_W'(HIST);
        end else if (w_asum >= $signed(OFF_W'(HIST))) begin
            w_asum = w_asum - OFF_W'(HIST);
        end
        w_raddr = AW'(w_asum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cell      <= '0;
            r_mac_vld   <= 1'b0;
            r_fw        <= WW'(RST_W);
            r_fh        <= HW'(MAX_HEIGHT);
            r_col       <= '0;
            r_row       <= '0;
            r_wptr      <= '0;
            r_wcnt      <= '0;
            r_ex        <= '0;
            r_ey        <= '0;
            r_eptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mac_vld  <= (r_state == S_GATHER) && (r_cell < CELL_W'(NCELL));
            r_mac_cell <= r_cell;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_hist_we) begin
                        if (w_first) begin
                            r_fw <= w_sat_w;
                            r_fh <= w_sat_h;
                        end
                        r_wptr <= (r_wptr == AW'(HIST - 1)) ? '0 : r_wptr + AW'(1);
                        r_wcnt <= n_wcnt;
                        if (r_col + WW'(1) >= w_fw_eff) begin
                            r_col <= '0;
                            r_row <= r_row + HW'(1);
                        end else begin
                            r_col <= r_col + WW'(1);
                        end
                    end
                    if (w_emit_start) begin
                        r_state <= S_GATHER;
                        r_cell  <= '0;
                    end
                end
                S_GATHER: begin
                    if (r_cell == CELL_W'(NCELL)) begin
                        r_state <= S_DIV;
                        r_cell  <= '0;
                    end else begin
                        r_cell <= r_cell + CELL_W'(1);
                    end
                end
                S_DIV: begin
                    if (r_cell == CELL_W'(DIV_STEPS + 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cell <= r_cell + CELL_W'(1);
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                        if (w_last) begin
                            r_col  <= '0;
                            r_row  <= '0;
                            r_wptr <= '0;
                            r_wcnt <= '0;
                            r_ex   <= '0;
                            r_ey   <= '0;
                            r_eptr <= '0;
                        end else begin
                            r_eptr <= (r_eptr == AW'(HIST - 1)) ? '0 : r_eptr + AW'(1);
                            if (r_ex == r_fw - WW'(1)) begin
                                r_ex <= '0;
                                r_ey <= r_ey + HW'(1);
                            end else begin
                                r_ex <= r_ex + WW'(1);
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [PIX_W-1:0] w_rdata;

    kif_history #(
        .DEPTH (HIST),
        .AW    (AW)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (r_wptr),
        .i_wdata ({i_blue, i_green, i_red}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    t_lane_ctl w_ctl;
    logic [7:0] w_level [3];

    assign w_ctl.clear     = w_emit_start;
    assign w_ctl.mac       = r_mac_vld;
    assign w_ctl.div_start = (r_state == S_DIV) && (r_cell == '0);

    for (genvar l = 0; l < 3; l++) begin : g_lane
        kif_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_coef   (w_coef[r_mac_cell]),
            .i_pix    (w_rdata[8*l +: 8]),
            .i_weight (r_weight),
            .o_level  (w_level[l])
        );
    end

    // merge the channel lanes into the output register; gray mode zeroes green and blue
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_red   <= w_level[0];
            r_out_green <= r_gray ? 8'd0 : w_level[1];
            r_out_blue  <= r_gray ? 8'd0 : w_level[2];
            r_out_last  <= w_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_red    = r_out_red;
    assign o_out_green  = r_out_green;
    assign o_out_blue   = r_out_blue;
    assign o_frame_last = r_out_last;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_wptr) < HIST) && (32'(r_eptr) < HIST))
        else $error("line memory pointer out of range");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hist_we |-> (r_row < r_fh))
        else $error("pixel stored after frame complete");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_row == '0 && r_col == '0 && r_wcnt == '0))
        else $error("counters not cleared after last pixel");

endmodule

`default_nettype wire

/* tb/sv/tb_kernel_3x3_image_filter.sv */
module tb_kernel_3x3_image_filter;
    import kif_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH  = 2 * KIF_MAX_WIDTH + 4;
    localparam int IDLE_LIMIT  = 6000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pixel_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;
    logic              i_valid;
    logic              o_ready;
    logic              i_op;
    logic [7:0]        i_red;
    logic [7:0]        i_green;
    logic [7:0]        i_blue;
    logic              o_valid;
    logic              i_ready;
    logic [7:0]        o_out_red;
    logic [7:0]        o_out_green;
    logic [7:0]        o_out_blue;
    logic              o_frame_last;

    kernel_3x3_image_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_frame_last (o_frame_last)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // filter model state
    logic [47:0] mask_rows [0:2];
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic        gray_reg;
    logic [23:0] line_hist [0:HIST_DEPTH-1];
    longint      weight_sum;
    int          col_pos;
    int          row_pos;
    int          out_index;
    int          frame_w;
    int          frame_h;
    bit          frame_done;

    t_pixel_out  filtered_q [$];
    int          failures;
    int          idle_cycles;
    int          hold_cycles;
    bit          no_gaps;

    function automatic longint coef(input int r, input int c);
        logic signed [15:0] v;
        v = mask_rows[r][16*c +: 16];
        return longint'(v);
    endfunction

    function automatic void update_weight();
        longint s;
        s = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                s += coef(r, c);
        weight_sum = s;
    endfunction

    function automatic void latch_frame_size();
        frame_w = (width_reg < 1) ? 1 : (width_reg > KIF_MAX_WIDTH) ? KIF_MAX_WIDTH : width_reg;
        frame_h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    function automatic logic [7:0] filter_lane(input logic [23:0] win [0:8], input int sh);
        longint s;
        longint q;
        s = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                s += coef(r, c) * longint'(win[r*3+c][sh +: 8]);
        q = (weight_sum > 0) ? s / weight_sum : s / 256;
        if (q > LEVEL_MAX) q = LEVEL_MAX;
        if (q < 0) q = 0;
        return q[7:0];
    endfunction

    function automatic t_pixel_out filter_next();
        t_pixel_out  res;
        logic [23:0] win [0:8];
        int          y;
        int          x;
        int          yy;
        int          xx;
        y = out_index / frame_w;
        x = out_index % frame_w;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                yy = y + dy;
                xx = x + dx;
                if (yy < 0) yy = 0;
                if (yy > frame_h - 1) yy = frame_h - 1;
                if (xx < 0) xx = 0;
                if (xx > frame_w - 1) xx = frame_w - 1;
                win[(dy+1)*3 + dx + 1] = line_hist[(yy * frame_w + xx) % HIST_DEPTH];
            end
        end
        res.red   = filter_lane(win, 0);
        res.green = gray_reg ? 8'd0 : filter_lane(win, 8);
        res.blue  = gray_reg ? 8'd0 : filter_lane(win, 16);
        res.last  = 1'b0;
        out_index++;
        if (out_index >= frame_w * frame_h) begin
            res.last   = 1'b1;
            row_pos    = 0;
            col_pos    = 0;
            out_index  = 0;
            frame_done = 1'b1;
        end
        return res;
    endfunction

    // advance the model by one accepted request
    function automatic void predict_filter(input bit op, input logic [23:0] pix);
        int rpos;
        if (row_pos >= frame_h) begin
            filtered_q.push_back(filter_next());
            return;
        end
        if (op) return;
        if (row_pos == 0 && col_pos == 0) begin
            latch_frame_size();
            out_index = 0;
        end
        rpos = row_pos * frame_w + col_pos;
        line_hist[rpos % HIST_DEPTH] = pix;
        col_pos++;
        if (col_pos >= frame_w) begin
            col_pos = 0;
            row_pos++;
        end
        if (rpos + 1 >= frame_w + 2)
            filtered_q.push_back(filter_next());
    endfunction

    function automatic int rand_gap();
        int p;
        if (no_gaps) return 0;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(3, 1);
        if (p < 98) return $urandom_range(15, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [7:0] rand_level();
        int p;
        p = $urandom_range(9);
        if (p == 0) return 8'd0;
        if (p == 1) return 8'd255;
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rand_coef();
        int p;
        p = $urandom_range(9);
        if (p < 5) return 16'($urandom_range(512));
        if (p < 7) return 16'(-$urandom_range(256));
        if (p == 7) return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
        return 16'($urandom);
    endfunction

    task automatic send_req(input bit op, input logic [7:0] r, g, b);
        int gap;
        i_valid <= 1'b1;
        i_op    <= op;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (!o_ready);
        predict_filter(op, {b, g, r});
        gap = rand_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MASK_TOP, REG_MASK_MIDDLE, REG_MASK_BOTTOM: begin
                mask_rows[idx] = value[47:0];
                update_weight();
            end
            REG_IMAGE_WIDTH: width_reg = value[10:0];
            REG_IMAGE_HGT:   height_reg = value[10:0];
            REG_GRAY_MODE:   gray_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic set_mask(input logic [47:0] top, mid, bot);
        cfg_write(REG_MASK_TOP, {16'd0, top});
        cfg_write(REG_MASK_MIDDLE, {16'd0, mid});
        cfg_write(REG_MASK_BOTTOM, {16'd0, bot});
    endtask

    task automatic random_mask();
        int p;
        p = $urandom_range(5);
        if (p == 0)
            set_mask(48'h0000_0100_0000, 48'h0100_0100_0100, 48'h0000_0100_0000);
        else
            set_mask({rand_coef(), rand_coef(), rand_coef()},
                     {rand_coef(), rand_coef(), rand_coef()},
                     {rand_coef(), rand_coef(), rand_coef()});
    endtask

    // one frame with random content and some noise, drained until its last pixel
    task automatic run_frame(input int noise_pct);
        int n;
        latch_frame_size();
        n = frame_w * frame_h;
        frame_done = 1'b0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct)
                send_req(1'b1, rand_level(), rand_level(), rand_level());
            send_req(1'b0, rand_level(), rand_level(), rand_level());
        end
        while (!frame_done) begin
            if ($urandom_range(99) < noise_pct)
                send_req(1'b0, rand_level(), rand_level(), rand_level());
            else
                send_req(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_directed();
        wait_idle();
        cfg_write(REG_IMAGE_WIDTH, 64'd3);
        cfg_write(REG_IMAGE_HGT, 64'd3);
        cfg_write(REG_GRAY_MODE, 64'd0);
        set_mask({16'h0100, 16'h7fff, 16'h8000}, {16'h0100, 16'h0200, 16'h0100},
                 {16'hff00, 16'h0000, 16'h0100});
        frame_done = 1'b0;
        // flush with no frame in progress is ignored
        send_req(1'b1, 8'hff, 8'hff, 8'hff);
        for (int i = 0; i < 9; i++)
            send_req(1'b0, (i % 2) ? 8'hff : 8'h00, 8'(i * 31), (i % 3) ? 8'h00 : 8'hff);
        // pixel after the frame is complete drains like a flush
        send_req(1'b0, 8'h55, 8'haa, 8'h55);
        while (!frame_done) send_req(1'b1, 8'h00, 8'h00, 8'h00);
        wait_idle();
        cfg_write(REG_GRAY_MODE, 64'd1);
        cfg_write(REG_IMAGE_WIDTH, 64'd2);
        cfg_write(REG_IMAGE_HGT, 64'd2);
        set_mask(48'h0, 48'hffff_0300_ffff, 48'h0);
        frame_done = 1'b0;
        send_req(1'b0, 8'hff, 8'h12, 8'h34);
        send_req(1'b0, 8'h00, 8'h56, 8'h78);
        send_req(1'b0, 8'h80, 8'h9a, 8'hbc);
        send_req(1'b0, 8'h7f, 8'hde, 8'hf0);
        while (!frame_done) send_req(1'b1, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_size_extremes();
        wait_idle();
        cfg_write(REG_GRAY_MODE, 64'd0);
        random_mask();
        cfg_write(REG_IMAGE_WIDTH, 64'd0);
        cfg_write(REG_IMAGE_HGT, 64'd2047);
        run_frame(2);
        wait_idle();
        cfg_write(REG_IMAGE_WIDTH, 64'd1);
        cfg_write(REG_IMAGE_HGT, 64'd0);
        run_frame(0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        cfg_write(REG_IMAGE_WIDTH, 64'd4);
        cfg_write(REG_IMAGE_HGT, 64'd5);
        hold_cycles = 500;
        no_gaps = 1'b1;
        run_frame(0);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_frames();
        int items;
        items = 0;
        while (items < 650) begin
            wait_idle();
            if ($urandom_range(3) == 0) random_mask();
            if ($urandom_range(3) == 0) cfg_write(REG_GRAY_MODE, 64'($urandom_range(1)));
            cfg_write(REG_IMAGE_WIDTH, 64'($urandom_range(12, 1)));
            cfg_write(REG_IMAGE_HGT, 64'($urandom_range(6, 1)));
            no_gaps = ($urandom_range(5) == 0);
            run_frame(8);
            items += frame_w * frame_h + frame_w + 1;
        end
        no_gaps = 1'b0;
        // raw request noise with a frame left open
        for (int i = 0; i < 60; i++)
            send_req(1'($urandom_range(1)), 8'($urandom), 8'($urandom), 8'($urandom));
        frame_done = 1'b0;
        while (!frame_done) send_req(1'b0, rand_level(), rand_level(), rand_level());
    endtask

    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (filtered_q.size() == 0) begin
                    $error("unexpected filtered pixel");
                    failures++;
                end else begin
                    t_pixel_out exp_px;
                    exp_px = filtered_q.pop_front();
                    if (o_out_red !== exp_px.red) begin
                        $error("out_red expected %0d actual %0d", exp_px.red, o_out_red);
                        failures++;
                    end
                    if (o_out_green !== exp_px.green) begin
                        $error("out_green expected %0d actual %0d", exp_px.green, o_out_green);
                        failures++;
                    end
                    if (o_out_blue !== exp_px.blue) begin
                        $error("out_blue expected %0d actual %0d", exp_px.blue, o_out_blue);
                        failures++;
                    end
                    if (o_frame_last !== exp_px.last) begin
                        $error("frame_last expected %0d actual %0d", exp_px.last, o_frame_last);
                        failures++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= (rand_gap() == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_kernel_3x3_image_filter failed");
            $finish;
        end
    end

    initial begin
        failures    = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        no_gaps     = 1'b0;
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_valid     = 1'b0;
        i_op        = 1'b0;
        i_red       = '0;
        i_green     = '0;
        i_blue      = '0;
        mask_rows[0] = 48'd0;
        mask_rows[1] = 48'd16777216;
        mask_rows[2] = 48'd0;
        width_reg   = 11'd1024;
        height_reg  = 11'd1024;
        gray_reg    = 1'b0;
        for (int i = 0; i < HIST_DEPTH; i++) line_hist[i] = '0;
        col_pos     = 0;
        row_pos     = 0;
        out_index   = 0;
        frame_done  = 1'b0;
        update_weight();
        latch_frame_size();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_frames();
        test_size_extremes();

        wait_idle();
        if (failures == 0)
            $display("tb_kernel_3x3_image_filter passed");
        else
            $display("tb_kernel_3x3_image_filter failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/kif_pkg.sv
rtl/core/kif_history.sv
rtl/core/kif_lane.sv
rtl/core/kernel_3x3_image_filter.sv
tb/sv/tb_kernel_3x3_image_filter.sv
